// ===== rtl/modbus_tcp_response_deframer_unit_macros.svh =====
// Assertion macros for the file that checks its own logic.
`ifndef MODBUS_TCP_RESPONSE_DEFRAMER_UNIT_MACROS_SVH
`define MODBUS_TCP_RESPONSE_DEFRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define MTRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MTRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MTRD_ASSERT_IMP(lbl, ante, cons)
`define MTRD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/mtrd_pkg.sv =====
package mtrd_pkg;

  localparam logic [2:0] HDR_LEN_POS   = 3'd5;
  localparam logic [2:0] HDR_CONTENT   = 3'd6;
  localparam int         FIELD_COUNT   = 6;
  localparam logic [7:0] FIELD_FIRST   = 8'd3;

  localparam logic [7:0] FC_WRITE_SWITCH = 8'h05;
  localparam logic [7:0] FC_READ_INPUT   = 8'h04;

  localparam logic [7:0] LEN_ECHO_MIN  = 8'd5;
  localparam logic [7:0] LEN_TWO_WORD  = 8'd7;
  localparam logic [7:0] LEN_THREE_WORD = 8'd9;

  localparam logic [1:0] KIND_ECHO       = 2'd0;
  localparam logic [1:0] KIND_TWO_WORD   = 2'd1;
  localparam logic [1:0] KIND_THREE_WORD = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  reg_addr;
    logic        switch_on;
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic [15:0] value_c;
    logic        run_flag;
    logic        remote_flag;
    logic [7:0]  content_len;
  } res_t;

endpackage

// ===== rtl/mtrd_in_if.sv =====
interface mtrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/mtrd_out_if.sv =====
interface mtrd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  reg_addr;
  logic        switch_on;
  logic [15:0] value_a;
  logic [15:0] value_b;
  logic [15:0] value_c;
  logic        run_flag;
  logic        remote_flag;
  logic [7:0]  content_len;

  modport source (output valid, output kind, output reg_addr, output switch_on,
                  output value_a, output value_b, output value_c, output run_flag,
                  output remote_flag, output content_len, input ready);
  modport sink (input valid, input kind, input reg_addr, input switch_on,
                input value_a, input value_b, input value_c, input run_flag,
                input remote_flag, input content_len, output ready);
endinterface

// ===== rtl/mtrd_frame.sv =====
module mtrd_frame
  import mtrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output res_t       res
);

  logic [2:0] hdr_pos_r, hdr_pos_nxt;
  logic [7:0] frame_len_r, frame_len_nxt;
  logic [7:0] cpos_r, cpos_nxt;
  logic [7:0] fc_r, fc_nxt;
  logic [7:0] fb_r [FIELD_COUNT];
  logic [7:0] fb_nxt [FIELD_COUNT];
  logic       run_r, run_nxt;
  logic       remote_r, remote_nxt;
  logic       done;
  logic       on;
  logic       is_echo;
  logic       is_read;

  always_comb begin
    hdr_pos_nxt   = hdr_pos_r;
    frame_len_nxt = frame_len_r;
    cpos_nxt      = cpos_r;
    fc_nxt        = fc_r;
    run_nxt       = run_r;
    remote_nxt    = remote_r;
    for (int i = 0; i < FIELD_COUNT; i++) begin
      fb_nxt[i] = fb_r[i];
    end
    done    = 1'b0;
    on      = 1'b0;
    is_echo = 1'b0;
    is_read = 1'b0;
    res       = '0;
    res_valid = 1'b0;

    if (hdr_pos_r < HDR_CONTENT) begin
      if (hdr_pos_r == HDR_LEN_POS) begin
        frame_len_nxt = rx_byte;
        cpos_nxt      = '0;
        hdr_pos_nxt   = (rx_byte == 8'd0) ? 3'd0 : HDR_CONTENT;
      end else begin
        hdr_pos_nxt = hdr_pos_r + 3'd1;
      end
    end else begin
      if (cpos_r == 8'd1) begin
        fc_nxt = rx_byte;
      end
      for (int i = 0; i < FIELD_COUNT; i++) begin
        if (cpos_r == FIELD_FIRST + 8'(i)) begin
          fb_nxt[i] = rx_byte;
        end
      end
      done     = ({1'b0, cpos_r} + 9'd1) >= {1'b0, frame_len_r};
      cpos_nxt = done ? 8'd0 : cpos_r + 8'd1;
      if (done) begin
        hdr_pos_nxt = 3'd0;
        on      = fb_nxt[1] != 8'd0;
        is_echo = (fc_nxt == FC_WRITE_SWITCH) && (frame_len_r >= LEN_ECHO_MIN);
        is_read = (fc_nxt == FC_READ_INPUT) &&
                  ((frame_len_r == LEN_TWO_WORD) || (frame_len_r == LEN_THREE_WORD));
        if (is_echo) begin
          if (fb_nxt[0] == 8'd0) begin
            run_nxt = on;
          end else begin
            remote_nxt = on;
          end
          res.kind      = KIND_ECHO;
          res.reg_addr  = fb_nxt[0];
          res.switch_on = on;
        end else if (is_read) begin
          res.value_a = {fb_nxt[0], fb_nxt[1]};
          res.value_b = {fb_nxt[2], fb_nxt[3]};
          if (frame_len_r == LEN_THREE_WORD) begin
            res.kind    = KIND_THREE_WORD;
            res.value_c = {fb_nxt[4], fb_nxt[5]};
          end else begin
            res.kind = KIND_TWO_WORD;
          end
        end
        res_valid       = is_echo || is_read;
        res.run_flag    = run_nxt;
        res.remote_flag = remote_nxt;
        res.content_len = frame_len_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r   <= '0;
      frame_len_r <= '0;
      cpos_r      <= '0;
      fc_r        <= '0;
      run_r       <= 1'b0;
      remote_r    <= 1'b0;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        fb_r[i] <= '0;
      end
    end else if (step) begin
      hdr_pos_r   <= hdr_pos_nxt;
      frame_len_r <= frame_len_nxt;
      cpos_r      <= cpos_nxt;
      fc_r        <= fc_nxt;
      run_r       <= run_nxt;
      remote_r    <= remote_nxt;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        fb_r[i] <= fb_nxt[i];
      end
    end
  end

endmodule

// ===== rtl/modbus_tcp_response_deframer_unit.sv =====
// Modbus-TCP response deframer. Bytes of the received stream enter on in_ch, one per
// transfer, and the block takes one byte every clock cycle as long as the result side
// keeps up. Each byte passes an input register and an update of the frame tracker. The
// result for a decoded frame is loaded into the out_ch register as its last content
// byte leaves the input register, which holds while the result side stalls. Only
// switch write echoes (code 5, at least five content bytes) and register reads (code 4
// with seven or nine content bytes) give a result; every other frame is consumed
// silently. The stored run and remote flags start cleared after reset, and the block
// needs no start-up time.
`include "modbus_tcp_response_deframer_unit_macros.svh"

module modbus_tcp_response_deframer_unit
  import mtrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mtrd_in_if.sink    in_ch,
  mtrd_out_if.source out_ch
);

  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       advance;
  logic       res_valid;
  res_t       res;
  logic       out_v_r;
  res_t       out_r;

  assign advance     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  mtrd_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .rx_byte   (s1_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= res_valid;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.reg_addr    = out_r.reg_addr;
  assign out_ch.switch_on   = out_r.switch_on;
  assign out_ch.value_a     = out_r.value_a;
  assign out_ch.value_b     = out_r.value_b;
  assign out_ch.value_c     = out_r.value_c;
  assign out_ch.run_flag    = out_r.run_flag;
  assign out_ch.remote_flag = out_r.remote_flag;
  assign out_ch.content_len = out_r.content_len;

  `MTRD_ASSERT_NXT(a_stage_holds, s1_v_r && out_v_r && !out_ch.ready,
                   s1_v_r && $stable(s1_byte_r))
  `MTRD_ASSERT_IMP(a_echo_no_words, out_v_r && out_r.kind == KIND_ECHO,
                   out_r.value_a == 16'd0 && out_r.value_b == 16'd0 &&
                   out_r.value_c == 16'd0)
  `MTRD_ASSERT_IMP(a_read_no_echo, out_v_r && out_r.kind != KIND_ECHO,
                   out_r.reg_addr == 8'd0 && !out_r.switch_on)

endmodule

// ===== test/mtrd_frame_checker.sv =====
module mtrd_frame_checker
  import mtrd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  mtrd_in_if   in_ch,
  mtrd_out_if  out_ch,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [2:0] hdr_idx;
  logic [7:0] body_len;
  logic [7:0] body_idx;
  logic [7:0] func;
  logic [7:0] kept[FIELD_COUNT];
  logic       run_st;
  logic       remote_st;

  res_t expected_replies[$];
  int   seen_errors;

  function automatic bit track_byte(input logic [7:0] b, output res_t r);
    logic [7:0] idx;
    logic       on;
    r = '0;
    if (hdr_idx < HDR_CONTENT) begin
      if (hdr_idx == HDR_LEN_POS) begin
        body_len = b;
        body_idx = 8'd0;
        hdr_idx  = (b == 8'd0) ? 3'd0 : HDR_CONTENT;
      end else begin
        hdr_idx = hdr_idx + 3'd1;
      end
      return 1'b0;
    end
    idx = body_idx;
    if (idx == 8'd1) begin
      func = b;
    end else if (idx >= FIELD_FIRST && idx < FIELD_FIRST + FIELD_COUNT) begin
      kept[idx - FIELD_FIRST] = b;
    end
    body_idx = idx + 8'd1;
    if ({1'b0, idx} + 9'd1 < {1'b0, body_len}) return 1'b0;

    hdr_idx  = 3'd0;
    body_idx = 8'd0;
    if (func == FC_WRITE_SWITCH && body_len >= LEN_ECHO_MIN) begin
      on = (kept[1] != 8'd0);
      if (kept[0] == 8'd0) begin
        run_st = on;
      end else begin
        remote_st = on;
      end
      r.kind      = KIND_ECHO;
      r.reg_addr  = kept[0];
      r.switch_on = on;
    end else if (func == FC_READ_INPUT &&
                 (body_len == LEN_TWO_WORD || body_len == LEN_THREE_WORD)) begin
      r.kind    = (body_len == LEN_TWO_WORD) ? KIND_TWO_WORD : KIND_THREE_WORD;
      r.value_a = {kept[0], kept[1]};
      r.value_b = {kept[2], kept[3]};
      if (body_len == LEN_THREE_WORD) r.value_c = {kept[4], kept[5]};
    end else begin
      return 1'b0;
    end
    r.run_flag    = run_st;
    r.remote_flag = remote_st;
    r.content_len = body_len;
    return 1'b1;
  endfunction

  task automatic flag_error(input string what, input res_t want, input res_t got);
    seen_errors++;
    if (seen_errors <= 10) begin
      $display("%0t: %s: expected %p, got %p", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    if (!rst_n) begin
      hdr_idx   = 3'd0;
      body_len  = 8'd0;
      body_idx  = 8'd0;
      func      = 8'd0;
      run_st    = 1'b0;
      remote_st = 1'b0;
      foreach (kept[i]) kept[i] = 8'd0;
      expected_replies.delete();
      seen_errors = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (track_byte(in_ch.rx_byte, want)) expected_replies.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.kind        = out_ch.kind;
        got.reg_addr    = out_ch.reg_addr;
        got.switch_on   = out_ch.switch_on;
        got.value_a     = out_ch.value_a;
        got.value_b     = out_ch.value_b;
        got.value_c     = out_ch.value_c;
        got.run_flag    = out_ch.run_flag;
        got.remote_flag = out_ch.remote_flag;
        got.content_len = out_ch.content_len;
        if (expected_replies.size() == 0) begin
          flag_error("result transfer with nothing expected", '0, got);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) flag_error("result mismatch", want, got);
        end
      end
    end
    errors  <= seen_errors;
    pending <= expected_replies.size();
  end
endmodule

// ===== test/modbus_tcp_response_deframer_unit_tb.sv =====
module modbus_tcp_response_deframer_unit_tb;
  import mtrd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 150;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;
  int   cycles;
  int   bytes_sent;
  int   hold_req;
  bit   no_idle;

  mtrd_in_if  in_ch();
  mtrd_out_if out_ch();

  modbus_tcp_response_deframer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mtrd_frame_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (fails),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The result side stalls at random, and holds off for a long stretch on request.
  initial begin : result_side
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= 18);
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    if (!no_idle && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 18);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_q_t content);
    repeat (5) put_byte(8'($urandom_range(255)));
    put_byte(8'(content.size()));
    foreach (content[i]) put_byte(content[i]);
  endtask

  function automatic byte_q_t random_content(input int n, input logic [7:0] code);
    byte_q_t c;
    for (int i = 0; i < n; i++) c.push_back(8'($urandom_range(255)));
    if (n > 1) c[1] = code;
    return c;
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    byte_q_t body;
    int      nf;
    int      pick;
    int      n;
    logic [7:0] code;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'd0;
    cycles        = 0;
    bytes_sent    = 0;
    hold_req      = 0;
    no_idle       = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    body = {};
    send_frame(body);
    body = random_content(5, FC_WRITE_SWITCH);
    body[3] = 8'h00;
    body[4] = 8'hFF;
    send_frame(body);
    body = random_content(6, FC_WRITE_SWITCH);
    body[3] = 8'hFF;
    body[4] = 8'h00;
    send_frame(body);
    body = random_content(5, FC_WRITE_SWITCH);
    body[3] = 8'h80;
    body[4] = 8'h01;
    send_frame(body);
    send_frame(random_content(4, FC_WRITE_SWITCH));
    body = random_content(7, FC_READ_INPUT);
    for (int i = 3; i < 7; i++) body[i] = 8'hFF;
    send_frame(body);
    body = random_content(9, FC_READ_INPUT);
    for (int i = 3; i < 9; i++) body[i] = 8'h00;
    send_frame(body);
    send_frame(random_content(8, FC_READ_INPUT));
    send_frame(random_content(7, 8'h83));
    send_frame(random_content(1, FC_READ_INPUT));
    send_frame(random_content(20, FC_READ_INPUT));
    body = random_content(12, FC_WRITE_SWITCH);
    body[3] = 8'h00;
    body[4] = 8'h00;
    send_frame(body);
    send_frame(random_content(255, FC_WRITE_SWITCH));

    nf = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      nf++;
      if (nf == 25) hold_req++;
      if (nf == 55) wait_drained();
      no_idle = (nf >= 80 && nf < 110);
      pick = $urandom_range(99);
      if (pick < 35) begin
        body = random_content($urandom_range(12, 5), FC_WRITE_SWITCH);
        if ($urandom_range(99) < 40) body[3] = 8'h00;
        if ($urandom_range(99) < 30) body[4] = 8'h00;
      end else if (pick < 65) begin
        n = ($urandom_range(1) == 0) ? 7 : 9;
        body = random_content(n, FC_READ_INPUT);
      end else if (pick < 77) begin
        code = ($urandom_range(1) == 0) ? FC_READ_INPUT : FC_WRITE_SWITCH;
        body = random_content($urandom_range(12), code);
      end else if (pick < 89) begin
        body = random_content($urandom_range(16), 8'($urandom_range(255)));
      end else if (pick < 99) begin
        code = ($urandom_range(1) == 0) ? FC_READ_INPUT : FC_WRITE_SWITCH;
        body = random_content($urandom_range(40, 13), code);
      end else begin
        body = random_content($urandom_range(255, 200), FC_WRITE_SWITCH);
      end
      send_frame(body);
    end
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== modbus_tcp_response_deframer_unit.f =====
+incdir+rtl
rtl/mtrd_pkg.sv
rtl/mtrd_in_if.sv
rtl/mtrd_out_if.sv
rtl/mtrd_frame.sv
rtl/modbus_tcp_response_deframer_unit.sv
test/mtrd_frame_checker.sv
test/modbus_tcp_response_deframer_unit_tb.sv
